[rtl/core/dtsf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the depth tested span fill block.
// Used by the datapath, controller and top level; depends on nothing.
package dtsf_pkg;

   localparam int X_W         = 8;
   localparam int ROW_W       = 8;
   localparam int Z_FIELD_W   = 24;
   localparam int COLOR_W     = 32;
   localparam int COUNT_W     = 17;
   localparam int OP_W        = 2;
   localparam int FRAC_W      = 16;
   localparam int REQ_DATA_W  = 104;
   localparam int RSP_DATA_W  = 24;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR     = 2'd0,
      OP_SET_PIXEL = 2'd1,
      OP_SPAN      = 2'd2
   } opcode_type;

   typedef struct packed {
      logic sweep;
      logic sweep_color;
      logic load;
      logic flip;
      logic set_px;
      logic div_start;
      logic span_init;
      logic issue;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       skip;
      logic       div_done;
      logic       x_last;
      logic       sweep_last;
      logic       rsp_busy;
   } status_type;

endpackage

[rtl/core/dtsf_divider.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by dtsf_datapath for the span depth step.
module dtsf_divider #(
   parameter int DIVIDEND_W = 40,
   parameter int DIVISOR_W  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   assign trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[DIVIDEND_W-2:0], fits};
         rem_ff  <= fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

[rtl/core/dtsf_datapath.sv]
`timescale 1ns / 1ps
// Datapath: command registers, colour and depth memories, span stepper,
// depth compare stage and result register. Uses dtsf_pkg and dtsf_divider.
module dtsf_datapath #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256,
   parameter int DEPTH_BITS   = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dtsf_pkg::cmd_type                cmd,
   output dtsf_pkg::status_type             status,
   input  dtsf_pkg::opcode_type             opcode,
   input  logic [dtsf_pkg::X_W-1:0]         x_start,
   input  logic [dtsf_pkg::X_W-1:0]         x_end,
   input  logic [dtsf_pkg::Z_FIELD_W-1:0]   z_start,
   input  logic [dtsf_pkg::Z_FIELD_W-1:0]   z_end,
   input  logic [dtsf_pkg::ROW_W-1:0]       row,
   input  logic [dtsf_pkg::COLOR_W-1:0]     color,
   input  logic                             rsp_tready,
   output logic                             rsp_valid,
   output logic [dtsf_pkg::COUNT_W-1:0]     pixels_written,
   output logic                             shown_buffer
);

   localparam int PIX  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW   = $clog2(PIX);
   localparam int RW   = $clog2(FRAME_HEIGHT);
   localparam int NW   = DEPTH_BITS + dtsf_pkg::FRAC_W;
   localparam int AC_W = NW + 1;
   localparam logic [DEPTH_BITS-1:0]        FAR     = '1;
   localparam logic [dtsf_pkg::COUNT_W-1:0] CLR_CNT = dtsf_pkg::COUNT_W'(PIX);

   logic [dtsf_pkg::COLOR_W-1:0] color_a [PIX];
   logic [dtsf_pkg::COLOR_W-1:0] color_b [PIX];
   logic [DEPTH_BITS-1:0]        depth_mem [PIX];

   dtsf_pkg::opcode_type         op_ff;
   logic [dtsf_pkg::X_W-1:0]     lo_ff, hi_ff, x_ff;
   logic [DEPTH_BITS-1:0]        zlo_ff, mag_ff;
   logic                         neg_ff, len_zero_ff, row_out_ff;
   logic [RW-1:0]                mrow_ff;
   logic [dtsf_pkg::COLOR_W-1:0] color_ff;
   logic [AW-1:0]                base_ff, sweep_ff, p_addr_ff;
   logic [AC_W-1:0]              acc_ff, step_ff;
   logic [dtsf_pkg::COUNT_W-1:0] count_ff, rsp_count_ff;
   logic                         front_ff, p_valid_ff, rsp_valid_ff, rsp_front_ff;
   logic [DEPTH_BITS-1:0]        p_depth_ff, rd_ff;

   logic                         swap;
   logic [DEPTH_BITS-1:0]        zs, ze, zhi;
   logic [dtsf_pkg::X_W-1:0]     lo_in, hi_in;
   logic [DEPTH_BITS-1:0]        zlo_in, mag_in;
   logic                         neg_in, len_zero_in, row_out_in;
   logic [RW-1:0]                mrow_in;

   logic [AW-1:0]                addr, cwaddr;
   logic [dtsf_pkg::COLOR_W-1:0] cwdata;
   logic                         col_ok, set_we, cmp_we, cwe, sweep_last;
   logic [NW-1:0]                quot;
   logic                         div_done;

   // word capture: order the span ends, depth delta as sign and magnitude
   assign swap        = (opcode == dtsf_pkg::OP_SPAN) && (x_start > x_end);
   assign zs          = DEPTH_BITS'(z_start);
   assign ze          = DEPTH_BITS'(z_end);
   assign lo_in       = swap ? x_end : x_start;
   assign hi_in       = swap ? x_start : x_end;
   assign zlo_in      = swap ? ze : zs;
   assign zhi         = swap ? zs : ze;
   assign neg_in      = zhi < zlo_in;
   assign mag_in      = neg_in ? (zlo_in - zhi) : (zhi - zlo_in);
   assign len_zero_in = lo_in == hi_in;
   assign row_out_in  = 32'(row) >= 32'(FRAME_HEIGHT);
   assign mrow_in     = RW'(FRAME_HEIGHT - 1) - RW'(row);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= opcode;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         zlo_ff      <= zlo_in;
         mag_ff      <= mag_in;
         neg_ff      <= neg_in;
         len_zero_ff <= len_zero_in;
         row_out_ff  <= row_out_in;
         mrow_ff     <= mrow_in;
         color_ff    <= color;
      end
      base_ff <= AW'(mrow_ff * FRAME_WIDTH);
   end

   dtsf_divider #(
      .DIVIDEND_W (NW),
      .DIVISOR_W  (dtsf_pkg::X_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({mag_ff, dtsf_pkg::FRAC_W'(0)}),
      .divisor  (hi_ff - lo_ff),
      .quotient (quot),
      .done     (div_done)
   );

   assign addr   = base_ff + AW'(x_ff);
   assign col_ok = 32'(x_ff) < 32'(FRAME_WIDTH);
   assign set_we = cmd.set_px && !row_out_ff && col_ok;
   assign cmp_we = p_valid_ff && (p_depth_ff < rd_ff);

   // span stepper: x counter and Q.16 depth accumulator
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= lo_in;
      end else if (cmd.issue) begin
         x_ff <= x_ff + 8'd1;
      end
      if (cmd.span_init) begin
         step_ff <= neg_ff ? (AC_W'(0) - {1'b0, quot}) : {1'b0, quot};
         acc_ff  <= {1'b0, zlo_ff, dtsf_pkg::FRAC_W'(0)};
      end else if (cmd.issue) begin
         acc_ff <= acc_ff + step_ff;
      end
      p_addr_ff  <= addr;
      p_depth_ff <= acc_ff[dtsf_pkg::FRAC_W +: DEPTH_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         front_ff   <= 1'b0;
         sweep_ff   <= '0;
      end else begin
         p_valid_ff <= cmd.issue && col_ok;
         if (cmd.flip) begin
            front_ff <= ~front_ff;
         end
         if (cmd.sweep) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
         end
      end
   end

   assign sweep_last = sweep_ff == AW'(PIX - 1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff <= '0;
      end else if (set_we) begin
         count_ff <= dtsf_pkg::COUNT_W'(1);
      end else if (cmp_we) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // depth memory: sweep to far, or compare stage write; registered read
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         depth_mem[sweep_ff] <= FAR;
      end else if (cmp_we) begin
         depth_mem[p_addr_ff] <= p_depth_ff;
      end
      rd_ff <= depth_mem[addr];
   end

   // colour writes always go to the back buffer
   assign cwe    = (cmd.sweep && cmd.sweep_color) || set_we || cmp_we;
   assign cwaddr = cmd.sweep ? sweep_ff : (cmp_we ? p_addr_ff : addr);
   assign cwdata = cmd.sweep ? '0 : color_ff;

   always_ff @(posedge clock) begin
      if (cwe && front_ff) begin
         color_a[cwaddr] <= cwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cwe && !front_ff) begin
         color_b[cwaddr] <= cwdata;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_count_ff <= (op_ff == dtsf_pkg::OP_CLEAR) ? CLR_CNT : count_ff;
         rsp_front_ff <= front_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign pixels_written = rsp_count_ff;
   assign shown_buffer   = rsp_front_ff;

   assign status.op         = op_ff;
   assign status.skip       = row_out_ff || len_zero_ff;
   assign status.div_done   = div_done;
   assign status.x_last     = 8'(x_ff + 8'd1) == hi_ff;
   assign status.sweep_last = sweep_last;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_tready;

   a_no_cmp_during_sweep: assert property (@(posedge clock) disable iff (reset)
      !(p_valid_ff && cmd.sweep))
      else $error("depth compare write overlaps sweep");

   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && opcode == dtsf_pkg::OP_SPAN) |=> (lo_ff <= hi_ff))
      else $error("span ends not ordered");

   a_issue_after_init: assert property (@(posedge clock) disable iff (reset)
      cmd.span_init |=> !p_valid_ff)
      else $error("compare stage busy at span start");

endmodule

[rtl/core/dtsf_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: reset sweep, word accept, command sequencing.
// Uses dtsf_pkg command and status types; drives dtsf_datapath.
module dtsf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  dtsf_pkg::status_type status,
   output dtsf_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_PREP,
      S_SETPX,
      S_DIV,
      S_SPAN,
      S_DRAIN,
      S_CLEAR,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep = 1'b1;
         end
         S_IDLE: begin
            cmd.load = req_tvalid && ready_ff;
         end
         S_PREP: begin
            cmd.flip      = status.op == dtsf_pkg::OP_CLEAR;
            cmd.div_start = (status.op == dtsf_pkg::OP_SPAN) && !status.skip;
         end
         S_SETPX: begin
            cmd.set_px = 1'b1;
         end
         S_DIV: begin
            cmd.span_init = status.div_done;
         end
         S_SPAN: begin
            cmd.issue = 1'b1;
         end
         S_CLEAR: begin
            cmd.sweep       = 1'b1;
            cmd.sweep_color = 1'b1;
         end
         S_FINISH: begin
            cmd.rsp_load = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_INIT: begin
               if (status.sweep_last) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_tvalid && ready_ff) begin
                  state_ff <= S_PREP;
                  ready_ff <= 1'b0;
               end
            end
            S_PREP: begin
               case (status.op)
                  dtsf_pkg::OP_CLEAR:     state_ff <= S_CLEAR;
                  dtsf_pkg::OP_SET_PIXEL: state_ff <= S_SETPX;
                  dtsf_pkg::OP_SPAN:      state_ff <= status.skip ? S_FINISH : S_DIV;
                  default:                state_ff <= S_FINISH;
               endcase
            end
            S_SETPX: begin
               state_ff <= S_FINISH;
            end
            S_DIV: begin
               if (status.div_done) begin
                  state_ff <= S_SPAN;
               end
            end
            S_SPAN: begin
               if (status.x_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_FINISH;
            end
            S_CLEAR: begin
               if (status.sweep_last) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!status.rsp_busy) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_tready = ready_ff;

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken while busy");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == S_IDLE))
      else $error("ready outside idle");

endmodule

[rtl/core/depth_tested_span_fill.sv]
`timescale 1ns / 1ps
// Top level: double-buffered framebuffer with depth buffer, span fill engine.
// Set pixel writes one pixel; span fill runs a divide state for the depth step, then walks
// the span; clear sweeps the whole frame.
// Throughput: one word in flight; next word taken while a result waits. Reset: synchronous;
// depth memory swept to far over every pixel with req_tready low, front buffer select cleared.
module depth_tested_span_fill #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256,
   parameter int DEPTH_BITS   = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // x_start[7:0], x_end[15:8], z_start[39:16], z_end[63:40], row[71:64],
   // color[103:72]
   input  logic [dtsf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode[1:0]
   input  logic [dtsf_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixels_written[16:0], shown_buffer[17], zero[23:18]
   output logic [dtsf_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   dtsf_pkg::cmd_type            cmd;
   dtsf_pkg::status_type         status;
   logic [dtsf_pkg::COUNT_W-1:0] pixels_written;
   logic                         shown_buffer;

   dtsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dtsf_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .DEPTH_BITS   (DEPTH_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .opcode         (dtsf_pkg::opcode_type'(req_tuser)),
      .x_start        (req_tdata[7:0]),
      .x_end          (req_tdata[15:8]),
      .z_start        (req_tdata[39:16]),
      .z_end          (req_tdata[63:40]),
      .row            (req_tdata[71:64]),
      .color          (req_tdata[103:72]),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .pixels_written (pixels_written),
      .shown_buffer   (shown_buffer)
   );

   assign rsp_tdata = {6'd0, shown_buffer, pixels_written};

endmodule

[bench/dtsf_outcome_checker.sv]
`timescale 1ns / 1ps
// Checker for depth_tested_span_fill: tracks the depth buffer and front select,
// predicts each response word and compares it field by field. Depends on dtsf_pkg.
module dtsf_outcome_checker #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256,
   parameter int DEPTH_BITS   = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [dtsf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [dtsf_pkg::OP_W-1:0]       req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [dtsf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              mismatches,
   output int                              owed_count
);

   localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
   localparam logic [DEPTH_BITS-1:0] FAR = '1;

   typedef struct packed {
      logic [dtsf_pkg::COLOR_W-1:0]   color;
      logic [dtsf_pkg::ROW_W-1:0]     row;
      logic [dtsf_pkg::Z_FIELD_W-1:0] z_end;
      logic [dtsf_pkg::Z_FIELD_W-1:0] z_start;
      logic [dtsf_pkg::X_W-1:0]       x_end;
      logic [dtsf_pkg::X_W-1:0]       x_start;
   } draw_word_type;

   typedef struct packed {
      logic [dtsf_pkg::COUNT_W-1:0] written;
      logic                         shown;
   } outcome_type;

   logic [DEPTH_BITS-1:0] depth_mem [PIXELS];
   logic                  front_sel;
   outcome_type           owed_outcomes [$];

   initial begin
      mismatches = 0;
      owed_count = 0;
      front_sel  = 1'b0;
      foreach (depth_mem[i]) depth_mem[i] = FAR;
   end

   function automatic int unsigned fill_span(input int unsigned xs, input int unsigned xe,
                                             input longint zs, input longint ze,
                                             input int unsigned r);
      int unsigned           lo, hi, len, addr, hits;
      longint                zlo, zhi, step, acc;
      logic [DEPTH_BITS-1:0] zpix;
      hits = 0;
      if (r >= FRAME_HEIGHT) return 0;
      if (xs > xe) begin
         lo = xe; hi = xs; zlo = ze; zhi = zs;
      end else begin
         lo = xs; hi = xe; zlo = zs; zhi = ze;
      end
      len = hi - lo;
      if (len == 0) return 0;
      // Q.16 step, truncated toward zero
      step = ((zhi - zlo) * 64'sd65536) / longint'(len);
      acc  = zlo * 64'sd65536;
      for (int unsigned x = lo; x < hi; x++) begin
         zpix = acc[dtsf_pkg::FRAC_W +: DEPTH_BITS];
         if (x < FRAME_WIDTH) begin
            addr = (FRAME_HEIGHT - 1 - r) * FRAME_WIDTH + x;
            if (zpix < depth_mem[addr]) begin
               depth_mem[addr] = zpix;
               hits++;
            end
         end
         acc += step;
      end
      return hits;
   endfunction

   function automatic outcome_type predict_outcome(input logic [dtsf_pkg::OP_W-1:0] op,
                                                   input draw_word_type w);
      int unsigned written;
      outcome_type o;
      written = 0;
      case (op)
         dtsf_pkg::OP_CLEAR: begin
            front_sel = ~front_sel;
            foreach (depth_mem[i]) depth_mem[i] = FAR;
            written = PIXELS;
         end
         dtsf_pkg::OP_SET_PIXEL: begin
            written = (w.row < FRAME_HEIGHT && w.x_start < FRAME_WIDTH) ? 1 : 0;
         end
         dtsf_pkg::OP_SPAN: begin
            written = fill_span(w.x_start, w.x_end, longint'(w.z_start & FAR),
                                longint'(w.z_end & FAR), w.row);
         end
         default: written = 0;
      endcase
      o.written = written[dtsf_pkg::COUNT_W-1:0];
      o.shown   = front_sel;
      return o;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_outcomes.size() == 0) begin
               $display("%0t: response word with none expected, tdata %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = owed_outcomes.pop_front();
               if (rsp_tdata[dtsf_pkg::COUNT_W-1:0] !== want.written) begin
                  $display("%0t: pixels_written expected %0d actual %0d", $time,
                           want.written, rsp_tdata[dtsf_pkg::COUNT_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[dtsf_pkg::COUNT_W] !== want.shown) begin
                  $display("%0t: shown_buffer expected %0d actual %0d", $time,
                           want.shown, rsp_tdata[dtsf_pkg::COUNT_W]);
                  mismatches++;
               end
               if (rsp_tdata[dtsf_pkg::RSP_DATA_W-1:dtsf_pkg::COUNT_W+1] !== '0) begin
                  $display("%0t: pad bits expected 0 actual %h", $time,
                           rsp_tdata[dtsf_pkg::RSP_DATA_W-1:dtsf_pkg::COUNT_W+1]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            owed_outcomes.push_back(predict_outcome(req_tuser, draw_word_type'(req_tdata)));
         owed_count <= owed_outcomes.size();
      end
   end

endmodule

[bench/tb_depth_tested_span_fill.sv]
`timescale 1ns / 1ps
// Testbench top for depth_tested_span_fill: directed and random draw commands with
// random idling on both sides; checking is in dtsf_outcome_checker. Depends on dtsf_pkg.
module tb_depth_tested_span_fill;

   localparam logic [dtsf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 4_000_000;
   localparam int RANDOM_WORDS = 450;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dtsf_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [dtsf_pkg::OP_W-1:0]       req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dtsf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int                              mismatches;
   int                              owed_count;
   int                              cycles = 0;

   depth_tested_span_fill u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dtsf_outcome_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .owed_count (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("tb_depth_tested_span_fill failed");
         $finish;
      end
   end

   // zero often, so that runs without idling occur
   function automatic int unsigned draw_wait();
      return ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic logic [dtsf_pkg::X_W-1:0] rand_x();
      return dtsf_pkg::X_W'($urandom());
   endfunction

   function automatic logic [dtsf_pkg::Z_FIELD_W-1:0] rand_z();
      return dtsf_pkg::Z_FIELD_W'($urandom());
   endfunction

   function automatic logic [dtsf_pkg::Z_FIELD_W-1:0] pick_depth();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return rand_z();
      endcase
   endfunction

   task automatic send_word(input logic [dtsf_pkg::OP_W-1:0] op,
                            input logic [dtsf_pkg::X_W-1:0] xs,
                            input logic [dtsf_pkg::X_W-1:0] xe,
                            input logic [dtsf_pkg::Z_FIELD_W-1:0] zs,
                            input logic [dtsf_pkg::Z_FIELD_W-1:0] ze,
                            input logic [dtsf_pkg::ROW_W-1:0] r,
                            input logic [dtsf_pkg::COLOR_W-1:0] color);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {color, r, ze, zs, xe, xs};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_outcomes();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
   endtask

   initial begin : receiver
      int unsigned stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int unsigned                  pick, lo, hi;
      int                           clears_left;
      logic [dtsf_pkg::X_W-1:0]     xs, xe;
      logic [dtsf_pkg::ROW_W-1:0]   r;
      clears_left = 3;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= dtsf_pkg::OP_CLEAR;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_word(dtsf_pkg::OP_SET_PIXEL, 8'd0, 8'd0, 24'd0, 24'd0, 8'd0, 32'h0000_0000);
      send_word(dtsf_pkg::OP_SET_PIXEL, 8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 8'd255,
                32'hFFFF_FFFF);
      send_word(dtsf_pkg::OP_SPAN, 8'd0, 8'd255, 24'hFFFFFF, 24'd0, 8'd0, 32'h1234_5678);
      send_word(dtsf_pkg::OP_SPAN, 8'd255, 8'd0, 24'd0, 24'd0, 8'd0, 32'hFFFF_FFFF);
      send_word(dtsf_pkg::OP_SPAN, 8'd255, 8'd0, 24'd0, 24'd0, 8'd0, 32'h0000_0001);
      send_word(dtsf_pkg::OP_SPAN, 8'd77, 8'd77, 24'd5, 24'd9, 8'd40, 32'hA5A5_A5A5);
      send_word(dtsf_pkg::OP_SPAN, 8'd0, 8'd255, 24'd0, 24'd0, 8'd255, 32'h5A5A_5A5A);
      send_word(dtsf_pkg::OP_SPAN, 8'd10, 8'd11, 24'hFFFFFF, 24'd0, 8'd128, 32'h0F0F_0F0F);
      send_word(dtsf_pkg::OP_SPAN, 8'd200, 8'd10, 24'd5, 24'd1000, 8'd128, 32'hF0F0_F0F0);
      send_word(OP_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 32'hFFFF_FFFF);
      send_word(dtsf_pkg::OP_SPAN, 8'd10, 8'd200, 24'd0, 24'hFFFFFF, 8'd128, 32'h0000_FFFF);
      send_word(dtsf_pkg::OP_CLEAR, 8'd0, 8'd0, 24'd0, 24'd0, 8'd0, 32'd0);
      send_word(dtsf_pkg::OP_SPAN, 8'd0, 8'd255, 24'd0, 24'd0, 8'd0, 32'hFFFF_0000);
      send_word(dtsf_pkg::OP_SET_PIXEL, 8'd128, 8'd3, 24'd0, 24'd0, 8'd128, 32'h5A5A_5A5A);
      send_word(dtsf_pkg::OP_CLEAR, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF,
                32'hFFFF_FFFF);
      send_word(dtsf_pkg::OP_SPAN, 8'd3, 8'd250, 24'hFFFFFF, 24'hFFFFFF, 8'd7, 32'h1111_1111);
      send_word(dtsf_pkg::OP_SPAN, 8'd1, 8'd254, 24'd1, 24'hFFFFFE, 8'd7, 32'h2222_2222);
      send_word(dtsf_pkg::OP_SPAN, 8'd254, 8'd1, 24'd0, 24'hFFFFFF, 8'd7, 32'h3333_3333);
      send_word(dtsf_pkg::OP_SPAN, 8'd0, 8'd5, 24'hFFFFFF, 24'hFFFFFA, 8'd9, 32'h4444_4444);
      wait_for_outcomes();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2) wait_for_outcomes();
         pick = $urandom_range(0, 99);
         // a few rows only, half the time, so spans overlap and the depth test bites
         r = $urandom_range(0, 1) ? dtsf_pkg::ROW_W'($urandom_range(0, 3))
                                  : dtsf_pkg::ROW_W'($urandom());
         if (pick < 2 && clears_left > 0) begin
            clears_left--;
            send_word(dtsf_pkg::OP_CLEAR, rand_x(), rand_x(), rand_z(), rand_z(), r,
                      $urandom());
         end else if (pick < 10) begin
            send_word(dtsf_pkg::OP_SET_PIXEL, rand_x(), rand_x(), rand_z(), rand_z(), r,
                      $urandom());
         end else if (pick < 13) begin
            send_word(OP_UNUSED, rand_x(), rand_x(), rand_z(), rand_z(), r, $urandom());
         end else begin
            if ($urandom_range(0, 9) < 6) begin
               lo = $urandom_range(0, 255);
               hi = lo + $urandom_range(0, 24);
               if (hi > 255) hi = 255;
               if ($urandom_range(0, 1)) begin
                  xs = dtsf_pkg::X_W'(lo); xe = dtsf_pkg::X_W'(hi);
               end else begin
                  xs = dtsf_pkg::X_W'(hi); xe = dtsf_pkg::X_W'(lo);
               end
            end else begin
               xs = rand_x();
               xe = rand_x();
            end
            send_word(dtsf_pkg::OP_SPAN, xs, xe, pick_depth(), pick_depth(), r, $urandom());
         end
      end

      wait_for_outcomes();
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("tb_depth_tested_span_fill passed");
      else
         $display("tb_depth_tested_span_fill failed");
      $finish;
   end

endmodule
